// ----- rtl/core/lbh_pkg.sv -----
package lbh_pkg;

    localparam int WORD_W      = 32;
    localparam int BUCKET_W    = 8;
    localparam int HASH_BITS_D = 8;
    localparam int JOB_DEPTH_D = 4;
    localparam int MIX_STEPS   = 9;
    localparam int STEP_W      = $clog2(MIX_STEPS);
    localparam int POS_W       = 4;
    localparam int HELD_W      = 24;

    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(11);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MIX_STEPS - 1);

    typedef enum logic [1:0] {
        JOB_BLOCK,
        JOB_FINAL,
        JOB_BLOCK_FINAL
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [WORD_W-1:0]  a_add;
        logic [WORD_W-1:0]  b_add;
        logic [WORD_W-1:0]  c_add;
    } job_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } words_t;

    typedef enum logic {
        B_IDLE,
        B_MIX
    } back_state_t;

    // one line of the mix per step
    function automatic words_t mix_step(input logic [STEP_W-1:0] step, input words_t m);
        words_t r;
        r = m;
        unique case (step)
            4'd0:    r.a = (m.a - m.b - m.c) ^ (m.c >> 13);
            4'd1:    r.b = (m.b - m.c - m.a) ^ (m.a << 8);
            4'd2:    r.c = (m.c - m.a - m.b) ^ (m.b >> 13);
            4'd3:    r.a = (m.a - m.b - m.c) ^ (m.c >> 12);
            4'd4:    r.b = (m.b - m.c - m.a) ^ (m.a << 16);
            4'd5:    r.c = (m.c - m.a - m.b) ^ (m.b >> 5);
            4'd6:    r.a = (m.a - m.b - m.c) ^ (m.c >> 3);
            4'd7:    r.b = (m.b - m.c - m.a) ^ (m.a << 10);
            4'd8:    r.c = (m.c - m.a - m.b) ^ (m.b >> 15);
            default: r = m;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/lookup2_bucket_hash.sv -----
// channel   signals                                                beat taken when
// key       key_valid key_stall key_byte byte_present last_byte    key_valid && !key_stall
// bucket    bucket_valid bucket_stall bucket                       bucket_valid && !bucket_stall
//
// one key byte per cycle while the job queue has room; a full 12-byte block is
// one job for the mixer, which loads a job and then mixes it one step at a time
// a key end costs one mix in the mixer, two for a key of exactly 12k bytes
// reset clears all words and counters at once, no clearing pass
// key_stall rises when the job queue is full; a stalled bucket holds in its
// output register and the mixer waits on the last step of a key end until the register frees
module lookup2_bucket_hash #(
    parameter int HASH_BITS = lbh_pkg::HASH_BITS_D,
    parameter int JOB_DEPTH = lbh_pkg::JOB_DEPTH_D
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         key_valid,
    output logic                         key_stall,
    input  logic [7:0]                   key_byte,
    input  logic                         byte_present,
    input  logic                         last_byte,
    output logic                         bucket_valid,
    input  logic                         bucket_stall,
    output logic [lbh_pkg::BUCKET_W-1:0] bucket
);
    import lbh_pkg::*;

    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic q_valid;
    job_t q_data;

    lbh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_byte     (key_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .q_full       (q_full),
        .push         (push),
        .push_job     (push_job)
    );

    lbh_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_data   (q_data)
    );

    lbh_back #(
        .HASH_BITS (HASH_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .bucket_valid (bucket_valid),
        .bucket_stall (bucket_stall),
        .bucket       (bucket)
    );

endmodule

// ----- rtl/core/lbh_front.sv -----
module lbh_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    key_valid,
    output logic                    key_stall,
    input  logic [7:0]              key_byte,
    input  logic                    byte_present,
    input  logic                    last_byte,
    input  logic                    q_full,
    output logic                    push,
    output lbh_pkg::job_t           push_job
);
    import lbh_pkg::*;

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              accept;
    logic              block_done;

    assign key_stall = q_full;
    assign accept    = key_valid && !q_full;

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        held_next  = held_reg;
        pos_next   = pos_reg;
        block_done = 1'b0;
        push       = 1'b0;
        push_job   = '0;
        if (accept)
        begin
            if (byte_present)
            begin
                priority if (pos_reg < POS_W'(4))
                begin
                    a_next[{pos_reg[1:0], 3'b000} +: 8] = key_byte;
                    pos_next = pos_reg + POS_W'(1);
                end
                else if (pos_reg < POS_W'(8))
                begin
                    b_next[{pos_reg[1:0], 3'b000} +: 8] = key_byte;
                    pos_next = pos_reg + POS_W'(1);
                end
                else if (pos_reg < LAST_POS)
                begin
                    held_next[{pos_reg[1:0], 3'b000} +: 8] = key_byte;
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    block_done = 1'b1;
                end
            end
            if (block_done)
            begin
                push           = 1'b1;
                push_job.kind  = last_byte ? JOB_BLOCK_FINAL : JOB_BLOCK;
                push_job.a_add = a_reg;
                push_job.b_add = b_reg;
                push_job.c_add = {key_byte, held_reg};
                a_next         = '0;
                b_next         = '0;
                held_next      = '0;
                pos_next       = '0;
            end
            else if (last_byte)
            begin
                push           = 1'b1;
                push_job.kind  = JOB_FINAL;
                push_job.a_add = a_next;
                push_job.b_add = b_next;
                push_job.c_add = WORD_W'(pos_next) + {held_next, 8'h00};
                a_next         = '0;
                b_next         = '0;
                held_next      = '0;
                pos_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            held_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            held_reg <= held_next;
            pos_reg  <= pos_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("block position out of range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (pos_reg == '0 && held_reg == '0 && a_reg == '0))
        else $error("front state not cleared after key end");

    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |-> (push && push_job.kind != JOB_BLOCK))
        else $error("key end without final job");

endmodule

// ----- rtl/core/lbh_jobq.sv -----
module lbh_jobq #(
    parameter int DEPTH = lbh_pkg::JOB_DEPTH_D
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  lbh_pkg::job_t           push_job,
    output logic                    full,
    input  logic                    pop,
    output logic                    q_valid,
    output lbh_pkg::job_t           q_data
);
    import lbh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t              slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ----- rtl/core/lbh_back.sv -----
module lbh_back #(
    parameter int HASH_BITS = lbh_pkg::HASH_BITS_D
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  lbh_pkg::job_t               q_data,
    output logic                        pop,
    output logic                        bucket_valid,
    input  logic                        bucket_stall,
    output logic [lbh_pkg::BUCKET_W-1:0] bucket
);
    import lbh_pkg::*;

    localparam logic [WORD_W-1:0] MASK = 32'hFFFF_FFFF >> (WORD_W - HASH_BITS);

    back_state_t         state_reg, state_next;
    words_t              words_reg, words_next;
    words_t              mixed;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                more_reg, more_next;
    logic                final_reg, final_next;
    logic                bucket_valid_reg, bucket_valid_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic                slot_free;
    logic                emit;

    assign mixed        = mix_step(step_reg, words_reg);
    assign slot_free    = !bucket_valid_reg || !bucket_stall;
    assign bucket_valid = bucket_valid_reg;
    assign bucket       = bucket_reg;

    always_comb
    begin
        state_next        = state_reg;
        words_next        = words_reg;
        step_next         = step_reg;
        more_next         = more_reg;
        final_next        = final_reg;
        bucket_valid_next = bucket_valid_reg && bucket_stall;
        bucket_next       = bucket_reg;
        pop               = 1'b0;
        emit              = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop          = 1'b1;
                    words_next.a = words_reg.a + q_data.a_add;
                    words_next.b = words_reg.b + q_data.b_add;
                    words_next.c = words_reg.c + q_data.c_add;
                    step_next    = '0;
                    more_next    = (q_data.kind == JOB_BLOCK_FINAL);
                    final_next   = (q_data.kind != JOB_BLOCK);
                    state_next   = B_MIX;
                end
            end
            B_MIX:
            begin
                priority if (step_reg != LAST_STEP)
                begin
                    words_next = mixed;
                    step_next  = step_reg + STEP_W'(1);
                end
                else if (more_reg)
                begin
                    words_next = mixed;
                    step_next  = '0;
                    more_next  = 1'b0;
                end
                else if (!final_reg)
                begin
                    words_next = mixed;
                    step_next  = '0;
                    state_next = B_IDLE;
                end
                else if (slot_free)
                begin
                    emit              = 1'b1;
                    bucket_valid_next = 1'b1;
                    bucket_next       = BUCKET_W'(mixed.c & MASK);
                    words_next        = '0;
                    step_next         = '0;
                    final_next        = 1'b0;
                    state_next        = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            words_reg        <= '0;
            step_reg         <= '0;
            more_reg         <= 1'b0;
            final_reg        <= 1'b0;
            bucket_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            words_reg        <= words_next;
            step_reg         <= step_next;
            more_reg         <= more_next;
            final_reg        <= final_next;
            bucket_valid_reg <= bucket_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bucket_reg <= bucket_next;
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_STEP)
        else $error("mix step out of range");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> (step_reg == '0 && !more_reg))
        else $error("idle mixer holds a step");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (bucket_valid_reg && words_reg == '0 && state_reg == B_IDLE))
        else $error("words not cleared after bucket");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> slot_free)
        else $error("bucket overwritten while stalled");

endmodule

// ----- tb/sv/lbh_bucket_check.sv -----
`timescale 1ns / 1ps

module lbh_bucket_check #(
    parameter int HASH_BITS = lbh_pkg::HASH_BITS_D
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         key_valid,
    input  logic                         key_stall,
    input  logic [7:0]                   key_byte,
    input  logic                         byte_present,
    input  logic                         last_byte,
    input  logic                         bucket_valid,
    input  logic                         bucket_stall,
    input  logic [lbh_pkg::BUCKET_W-1:0] bucket,
    output int                           outstanding,
    output int                           mismatches
);

    localparam logic [31:0] BUCKET_MASK = 32'hFFFF_FFFF >> (32 - HASH_BITS);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } hash_words_t;

    hash_words_t                   words;
    logic [23:0]                   held_c;
    logic [3:0]                    fill;
    logic [lbh_pkg::BUCKET_W-1:0]  buckets_due[$];
    logic [lbh_pkg::BUCKET_W-1:0]  due;

    function automatic hash_words_t lookup2_mix(input hash_words_t w);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        x = w.a;
        y = w.b;
        z = w.c;
        x = (x - y - z) ^ (z >> 13);
        y = (y - z - x) ^ (x << 8);
        z = (z - x - y) ^ (y >> 13);
        x = (x - y - z) ^ (z >> 12);
        y = (y - z - x) ^ (x << 16);
        z = (z - x - y) ^ (y >> 5);
        x = (x - y - z) ^ (z >> 3);
        y = (y - z - x) ^ (x << 10);
        z = (z - x - y) ^ (y >> 15);
        return '{a: x, b: y, c: z};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words = '0;
            held_c = '0;
            fill = '0;
            buckets_due.delete();
            outstanding <= 0;
            mismatches <= 0;
        end
        else
        begin
            // bucket side first: a bucket never belongs to a key ending on this edge
            if (bucket_valid && !bucket_stall)
            begin
                if (buckets_due.size() == 0)
                begin
                    $display("%0t: bucket beat with none due, actual %h", $time, bucket);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    due = buckets_due.pop_front();
                    if (bucket !== due)
                    begin
                        $display("%0t: bucket expected %h actual %h", $time, due, bucket);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (key_valid && !key_stall)
            begin
                if (byte_present)
                begin
                    if (fill < 4)
                    begin
                        words.a = words.a + (32'(key_byte) << (8 * fill));
                        fill = fill + 1;
                    end
                    else if (fill < 8)
                    begin
                        words.b = words.b + (32'(key_byte) << (8 * (fill - 4)));
                        fill = fill + 1;
                    end
                    else if (fill < 11)
                    begin
                        held_c = held_c | (24'(key_byte) << (8 * (fill - 8)));
                        fill = fill + 1;
                    end
                    else
                    begin
                        words.c = words.c + {key_byte, held_c};
                        words = lookup2_mix(words);
                        held_c = '0;
                        fill = '0;
                    end
                end
                if (last_byte)
                begin
                    // leftover count, then bytes 8 to 10 one byte up
                    words.c = words.c + 32'(fill) + {held_c, 8'h00};
                    words = lookup2_mix(words);
                    buckets_due.push_back(lbh_pkg::BUCKET_W'(words.c & BUCKET_MASK));
                    words = '0;
                    held_c = '0;
                    fill = '0;
                end
            end
            outstanding <= buckets_due.size();
        end
    end

endmodule

// ----- tb/sv/lookup2_bucket_hash_tb.sv -----
`timescale 1ns / 1ps

module lookup2_bucket_hash_tb;

    localparam int ITEM_GOAL  = 1700;
    localparam int IDLE_LIMIT = 4000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         key_valid = 1'b0;
    logic [7:0]                   key_byte = 8'h00;
    logic                         byte_present = 1'b0;
    logic                         last_byte = 1'b0;
    logic                         bucket_stall = 1'b0;
    logic                         key_stall;
    logic                         bucket_valid;
    logic [lbh_pkg::BUCKET_W-1:0] bucket;

    int outstanding;
    int mismatches;
    int items_sent = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit rush = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lookup2_bucket_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_byte     (key_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .bucket_valid (bucket_valid),
        .bucket_stall (bucket_stall),
        .bucket       (bucket)
    );

    lbh_bucket_check bucket_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_byte     (key_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .bucket_valid (bucket_valid),
        .bucket_stall (bucket_stall),
        .bucket       (bucket),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    // receiver holds off a drawn number of cycles per bucket
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left = 0;
            bucket_stall <= 1'b0;
        end
        else
        begin
            if (bucket_valid && !bucket_stall)
                hold_left = rush ? 0 : $urandom_range(0, 8);
            else if (bucket_valid && hold_left > 0)
                hold_left = hold_left - 1;
            bucket_stall <= (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((key_valid && !key_stall) || (bucket_valid && !bucket_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 8);
        repeat (gap)
        begin
            key_valid <= 1'b0;
            @(posedge clk);
        end
        key_valid <= 1'b1;
        key_byte <= b;
        byte_present <= present;
        last_byte <= last;
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
        if (present)
            items_sent = items_sent + 1;
    endtask

    task automatic send_key(input int len);
        int pattern;
        bit absent_end;
        logic [7:0] b;
        pattern = $urandom_range(0, 9);
        absent_end = ($urandom_range(0, 5) == 0);
        rush <= ($urandom_range(0, 4) == 0);
        if (len == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
        else
        begin
            for (int i = 0; i < len; i++)
            begin
                // absent bytes in the middle change nothing
                if ($urandom_range(0, 15) == 0)
                    send_beat(8'($urandom), 1'b0, 1'b0);
                b = (pattern == 0) ? 8'hFF : (pattern == 1) ? 8'h00 : 8'($urandom);
                send_beat(b, 1'b1, !absent_end && (i == len - 1));
            end
            if (absent_end)
                send_beat(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        int len;
        int pick;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty key, one-byte key, one full block of ones
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        for (int i = 0; i < 12; i++)
            send_beat(8'hFF, 1'b1, i == 11);
        // ten bytes with an absent byte inside and an absent last beat
        for (int i = 0; i < 10; i++)
        begin
            if (i == 5)
                send_beat(8'hA5, 1'b0, 1'b0);
            send_beat(8'(i * 29 + 1), 1'b1, 1'b0);
        end
        send_beat(8'h5A, 1'b0, 1'b1);

        while (items_sent < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                len = 12 * $urandom_range(1, 3);
            else if (pick < 8)
                len = $urandom_range(0, 23);
            else
                len = $urandom_range(24, 60);
            send_key(len);
        end

        key_valid <= 1'b0;
        rush <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/lbh_pkg.sv
rtl/core/lbh_front.sv
rtl/core/lbh_jobq.sv
rtl/core/lbh_back.sv
rtl/core/lookup2_bucket_hash.sv
tb/sv/lbh_bucket_check.sv
tb/sv/lookup2_bucket_hash_tb.sv
